/* sv/assert_macros.svh */
// Assertion macros used by the checker file of the receive filter.
// Each macro expects i_clk, and all but the last also i_rst_n, to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ERAF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("receive filter check failed");

// Next-cycle implication, disabled while reset is held
`define ERAF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("receive filter check failed");

// Next-cycle implication that also covers the reset cycles
`define ERAF_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("receive filter check failed");

`endif

/* sv/eraf_pkg.sv */
// Package of the Ethernet receive address and type filter.
// Holds header positions, register indexes, the result type and the type check.
package eraf_pkg;

    localparam int MAX_TYPES       = 2;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 48;

    // Header byte positions
    localparam logic [3:0] POS_SRC    = 4'd6;
    localparam logic [3:0] POS_TYPE   = 4'd12;
    localparam logic [3:0] POS_DECIDE = 4'd13;
    localparam logic [3:0] HDR_LEN    = 4'd14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RX_ENABLE   = 3'd0,
        CFG_OWN_MAC     = 3'd1,
        CFG_TYPE_FIRST  = 3'd2,
        CFG_TYPE_SECOND = 3'd3,
        CFG_TYPE_COUNT  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [47:0] source_mac;
        logic [15:0] frame_type;
        logic        payload_last;
    } t_result;

    // Match a type against the first 'count' accepted types, capped by MAX_TYPES and two
    function automatic logic type_ok(input logic [15:0] t, input logic [1:0] count,
                                     input logic [15:0] first, input logic [15:0] second);
        logic [1:0] limit;
        limit = count;
        if (int'(limit) > MAX_TYPES) limit = 2'(MAX_TYPES);
        if (limit > 2'd2) limit = 2'd2;
        return ((limit >= 2'd1) && (t == first)) || ((limit >= 2'd2) && (t == second));
    endfunction

endpackage

/* sv/eraf_if.sv */
// Channel interfaces of the receive filter: byte input, result output, register writes.
// Depends on eraf_pkg for widths.
interface eraf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface eraf_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [47:0] source_mac;
    logic [15:0] frame_type;
    logic        payload_last;

    modport source (output valid, payload_byte, payload_valid, source_mac, frame_type,
                    payload_last, input ready);
    modport sink   (input valid, payload_byte, payload_valid, source_mac, frame_type,
                    payload_last, output ready);
endinterface

interface eraf_cfg_if import eraf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

/* sv/eraf_queue.sv */
// Short result queue between the classifying front and the output stage.
// Depends on eraf_pkg for the result type.
module eraf_queue import eraf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_full,
    input  logic    i_pop,
    output t_result o_head,
    output logic    o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Advance pointers with explicit wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* sv/eraf_front.sv */
// Front of the receive filter: register writes, header tracking and frame decision.
// Depends on eraf_pkg and the channel interfaces; feeds results into eraf_queue.
module eraf_front import eraf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    eraf_byte_if.sink i_in,
    eraf_cfg_if.sink  i_cfg,
    input  logic    i_q_full,
    output logic    o_push,
    output t_result o_push_data
);
    logic        r_rx_enable;
    logic [47:0] r_own_mac;
    logic [15:0] r_type_first;
    logic [15:0] r_type_second;
    logic [1:0]  r_type_count;

    logic [3:0]  r_pos,     n_pos;
    logic        r_match,   n_match;
    logic        r_accept,  n_accept;
    logic [47:0] r_src,     n_src;
    logic [15:0] r_type,    n_type;

    logic        take;
    logic [7:0]  b;
    logic [7:0]  own_byte;
    logic [15:0] type_new;
    logic        decide_ok;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign take        = i_in.valid && !i_q_full;
    assign b           = i_in.frame_byte;
    assign type_new    = {r_type[7:0], b};
    assign decide_ok   = r_rx_enable && r_match &&
                         type_ok(type_new, r_type_count, r_type_first, r_type_second);

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_enable   <= 1'b0;
            r_own_mac     <= '0;
            r_type_first  <= '0;
            r_type_second <= '0;
            r_type_count  <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.reg_index))
                CFG_RX_ENABLE:   r_rx_enable   <= i_cfg.wr_data[0];
                CFG_OWN_MAC:     r_own_mac     <= i_cfg.wr_data[47:0];
                CFG_TYPE_FIRST:  r_type_first  <= i_cfg.wr_data[15:0];
                CFG_TYPE_SECOND: r_type_second <= i_cfg.wr_data[15:0];
                CFG_TYPE_COUNT:  r_type_count  <= i_cfg.wr_data[1:0];
                default: ;
            endcase
        end
    end

    // Pick the station address byte expected at this position
    always_comb begin
        case (r_pos)
            4'd0:    own_byte = r_own_mac[47:40];
            4'd1:    own_byte = r_own_mac[39:32];
            4'd2:    own_byte = r_own_mac[31:24];
            4'd3:    own_byte = r_own_mac[23:16];
            4'd4:    own_byte = r_own_mac[15:8];
            default: own_byte = r_own_mac[7:0];
        endcase
    end

    // Track the header and decide on the frame
    always_comb begin
        n_pos       = r_pos;
        n_match     = r_match;
        n_accept    = r_accept;
        n_src       = r_src;
        n_type      = r_type;
        o_push      = 1'b0;
        o_push_data = '{payload_byte: b, payload_valid: 1'b1, source_mac: r_src,
                        frame_type: r_type, payload_last: i_in.frame_end};
        if (take) begin
            if (r_pos < POS_SRC) begin
                if (own_byte != b) n_match = 1'b0;
            end else if (r_pos < POS_TYPE) begin
                n_src = {r_src[39:0], b};
            end else if (r_pos < HDR_LEN) begin
                n_type = type_new;
                if (r_pos == POS_DECIDE) begin
                    n_accept = decide_ok;
                    // Header-only frame: one notice without a byte
                    if (decide_ok && i_in.frame_end) begin
                        o_push = 1'b1;
                        o_push_data = '{payload_byte: 8'd0, payload_valid: 1'b0,
                                        source_mac: r_src, frame_type: type_new,
                                        payload_last: 1'b1};
                    end
                end
            end else if (r_accept) begin
                o_push = 1'b1;
            end
            if (i_in.frame_end) begin
                n_pos    = '0;
                n_match  = 1'b1;
                n_accept = 1'b0;
            end else if (r_pos < HDR_LEN) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_match  <= 1'b1;
            r_accept <= 1'b0;
            r_src    <= '0;
            r_type   <= '0;
        end else begin
            r_pos    <= n_pos;
            r_match  <= n_match;
            r_accept <= n_accept;
            r_src    <= n_src;
            r_type   <= n_type;
        end
    end

endmodule

/* sv/eraf_back.sv */
// Back of the receive filter: output register fed from the result queue.
// Depends on eraf_pkg and the result interface.
module eraf_back import eraf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_result i_q_head,
    output logic    o_pop,
    eraf_result_if.source o_out
);
    logic    r_valid, n_valid;
    t_result r_data;

    // Refill the output register whenever it is empty or being taken
    assign o_pop = !i_q_empty && (!r_valid || o_out.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_head;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.payload_byte  = r_data.payload_byte;
    assign o_out.payload_valid = r_data.payload_valid;
    assign o_out.source_mac    = r_data.source_mac;
    assign o_out.frame_type    = r_data.frame_type;
    assign o_out.payload_last  = r_data.payload_last;

endmodule

/* sv/ethernet_rx_address_type_filter_core.sv */
// Ethernet receive filter on destination address and EtherType.
// Usage:
//   i_in  : one frame byte per item, frame_end marks the final byte.
//   i_cfg : register writes (enable, station MAC, two types, type count), always
//           ready; must be written only while the block is idle (unenforced).
//   o_out : one result per payload byte of an accepted frame, tagged with
//           source MAC and type; a header-only accepted frame gives one
//           notice with payload_valid low and payload_last high.
// The first 14 bytes of each frame are the header and give no result;
// the decision is taken on the fourteenth byte, shorter frames are dropped.
// A payload byte is registered in the queue and then in the output register.
// Throughput: one byte per cycle while the queue is not full; the front
// decides combinationally and a short queue feeds the output register.
// When o_out stalls, the queue fills and i_in.ready drops once it is full.
// Reset (synchronous, active low) zeroes the control registers but the match
// flag (set), empties the queue, restarts the frame; no clearing pass needed.
// Depends on eraf_pkg, the channel interfaces, eraf_front, eraf_queue, eraf_back.
module ethernet_rx_address_type_filter_core import eraf_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    eraf_byte_if.sink     i_in,
    eraf_cfg_if.sink      i_cfg,
    eraf_result_if.source o_out
);
    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    t_result push_data;
    t_result q_head;

    eraf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    eraf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_head      (q_head),
        .o_empty     (q_empty)
    );

    eraf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

/* sv/eraf_checker.sv */
// Port-level checks of the receive filter and the bind that attaches them.
// Depends on assert_macros.svh and the top level ethernet_rx_address_type_filter_core.
`include "assert_macros.svh"

module eraf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [73:0] i_out_data
);
    // Output register is empty right after reset
    `ERAF_ASSERT_NEXT_ALWAYS(a_out_idle_after_reset, !i_rst_n, !i_out_valid)

    // Input back-pressure only when a result is already waiting
    `ERAF_ASSERT_SAME(a_stall_has_result, !i_in_ready, i_out_valid)

    // A stalled result stays offered
    `ERAF_ASSERT_NEXT(a_out_valid_held, i_out_valid && !i_out_ready, i_out_valid)

    // A stalled result keeps its contents
    `ERAF_ASSERT_NEXT(a_out_data_held, i_out_valid && !i_out_ready, $stable(i_out_data))

endmodule

bind ethernet_rx_address_type_filter_core eraf_checker u_eraf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  ({o_out.payload_byte, o_out.payload_valid, o_out.source_mac,
                   o_out.frame_type, o_out.payload_last})
);
